[rtl/cvdt_pkg.sv]
package cvdt_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned ColorWords = 4;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_FULL_STENCIL = 2'd2,
    ST_INVALID      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_COLOR   = 2'd1,
    KIND_DEPTH   = 2'd2,
    KIND_STENCIL = 2'd3
  } kind_e;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [0:0] REG_TABLE_ENTRIES  = 1'd0;
  localparam logic [0:0] REG_STENCIL_ENABLE = 1'd1;

  localparam logic [15:0] RefMax = 16'hFFFF;

  // one slot of any table: four words, scalar value, format, count
  typedef struct packed {
    logic [63:0] ds_low;
    logic [63:0] ds_high;
    logic [63:0] l2_low;
    logic [63:0] l2_high;
    logic [31:0] value;
    logic [7:0]  fmt;
    logic [15:0] refs;
  } slot_t;

endpackage

[rtl/cvdt_store.sv]
// Slot memory for the three tables; one synchronous read port, one write port.
module cvdt_store #(
  parameter int unsigned TableDepth = cvdt_pkg::TableDepth,
  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1
) (
  input  logic                clk_i,
  input  logic [1:0]          rd_tbl_i,
  input  logic [AW-1:0]       rd_addr_i,
  output cvdt_pkg::slot_t     rd_data_o,
  input  logic                wr_en_i,
  input  logic [1:0]          wr_tbl_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  cvdt_pkg::slot_t     wr_data_i
);

  cvdt_pkg::slot_t mem [3*TableDepth];

  function automatic logic [$clog2(3*TableDepth)-1:0] flat(
    input logic [1:0] t, input logic [AW-1:0] a);
    logic [$clog2(3*TableDepth)+1:0] f;
    begin
      f = ($clog2(3*TableDepth)+2)'(t - 2'd1) * ($clog2(3*TableDepth)+2)'(TableDepth)
          + ($clog2(3*TableDepth)+2)'(a);
      return f[$clog2(3*TableDepth)-1:0];
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[flat(wr_tbl_i, wr_addr_i)] <= wr_data_i;
    end
    rd_data_o <= mem[flat(rd_tbl_i, rd_addr_i)];
  end

endmodule

[rtl/clear_value_dedup_table_top.sv]
// Channel   | Dir | Handshake               | Payload
// req       | in  | req_valid_i/req_stall_o | operation .. entry_index
// rsp       | out | rsp_valid_o/rsp_stall_i | status .. read_depth
// cfg       | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request at a time. An add walks the used slots, one memory read per
// cycle, and stops at the first match: it passes through idle, a check step
// for each slot compared (at least one) and an output step. A query passes
// through idle, a read step and output; an invalid kind goes from idle straight
// to output. Reset clears control state at once; slots read as zero until
// written through valid bits held in flip-flops.
// The result waits in an output register while rsp_stall_i is high.
module clear_value_dedup_table_top #(
  parameter int unsigned TableDepth = cvdt_pkg::TableDepth,
  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  localparam int unsigned CW = $clog2(TableDepth + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic        operation_i,
  input  logic [1:0]  table_kind_i,
  input  logic [7:0]  format_i,
  input  logic [63:0] color_ds_low_i,
  input  logic [63:0] color_ds_high_i,
  input  logic [63:0] color_l2_low_i,
  input  logic [63:0] color_l2_high_i,
  input  logic [31:0] depth_value_i,
  input  logic [7:0]  entry_index_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output logic [1:0]  status_o,
  output logic [4:0]  slot_index_o,
  output logic        wrote_new_o,
  output logic [7:0]  read_format_o,
  output logic [15:0] ref_count_o,
  output logic [63:0] read_ds_low_o,
  output logic [63:0] read_ds_high_o,
  output logic [63:0] read_l2_low_o,
  output logic [63:0] read_l2_high_o,
  output logic [31:0] read_depth_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CHECK = 5'b00100,
    S_QRD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [4:0] entries_q;
  logic       sten_en_q;
  logic [CW-1:0] used_q [3];
  logic [TableDepth-1:0] vld_q [3];

  // latched request
  logic [1:0]  kind_q;
  cvdt_pkg::slot_t key_q;
  logic [7:0]  idx_q;

  logic [AW-1:0] ptr_q, ptr_d;
  logic [CW:0]   cnt_q;  // slots still to compare

  // result register
  logic        rsp_valid_q;
  logic [1:0]  status_q;
  logic [4:0]  slot_q;
  logic        new_q;
  cvdt_pkg::slot_t rd_q;

  cvdt_pkg::slot_t rd_data, rd_eff, wr_data;
  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [1:0] ti;  // table number 0..2

  logic [CW-1:0] eff;
  assign eff = (32'(entries_q) > TableDepth) ? CW'(TableDepth) : CW'(entries_q);

  assign req_stall_o = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign ti = kind_q - 2'd1;

  // a query reads its slot at once, an add starts its walk at slot 0
  logic [AW-1:0] rd_sel;
  assign rd_sel  = (state_q == S_IDLE && operation_i == cvdt_pkg::OP_QUERY)
                   ? AW'(entry_index_i) : ptr_d;
  assign rd_addr = rd_sel;

  cvdt_store #(.TableDepth(TableDepth)) u_store (
    .clk_i     (clk_i),
    .rd_tbl_i  ((state_q == S_IDLE) ? table_kind_i : kind_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_tbl_i  (kind_q),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // slot read of last cycle, zero when never written
  logic [AW-1:0] rptr_q;
  always_comb begin
    rd_eff = rd_data;
    if (kind_q == cvdt_pkg::KIND_NONE || !vld_q[ti][rptr_q]) rd_eff = '0;
    if (kind_q != cvdt_pkg::KIND_COLOR) begin
      rd_eff.ds_low = '0; rd_eff.ds_high = '0; rd_eff.l2_low = '0; rd_eff.l2_high = '0;
    end
  end

  logic hit;
  always_comb begin
    hit = (rd_eff.refs != 16'd0) && (rd_eff.fmt == key_q.fmt);
    if (kind_q == cvdt_pkg::KIND_COLOR) begin
      hit = hit && rd_eff.ds_low == key_q.ds_low && rd_eff.ds_high == key_q.ds_high
            && rd_eff.l2_low == key_q.l2_low && rd_eff.l2_high == key_q.l2_high;
    end else begin
      hit = hit && rd_eff.value == key_q.value;
    end
  end

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    wr_en   = 1'b0;
    wr_addr = rptr_q;
    wr_data = rd_eff;
    case (state_q)
      S_IDLE: begin
        ptr_d = '0;
        if (req_valid_i) begin
          if (table_kind_i == cvdt_pkg::KIND_NONE
              || (table_kind_i == cvdt_pkg::KIND_STENCIL && !sten_en_q)) begin
            state_d = S_OUT;
          end else if (operation_i == cvdt_pkg::OP_QUERY) begin
            state_d = S_QRD;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // rd_eff holds slot rptr_q when cnt_q != 0
        if (cnt_q != '0 && hit) begin
          wr_en = 1'b1;
          wr_data.refs = (rd_eff.refs == cvdt_pkg::RefMax) ? cvdt_pkg::RefMax
                         : rd_eff.refs + 16'd1;
          state_d = S_OUT;
        end else if (cnt_q <= (CW+1)'(1)) begin
          if (used_q[ti] < eff) begin
            wr_en   = 1'b1;
            wr_addr = AW'(used_q[ti]);
            wr_data = key_q;
            wr_data.refs = 16'd1;
          end
          state_d = S_OUT;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      S_QRD:   state_d = S_OUT;
      S_OUT:   if (!rsp_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      entries_q   <= 5'd16;
      sten_en_q   <= 1'b1;
      used_q      <= '{default: '0};
      vld_q       <= '{default: '0};
      rsp_valid_q <= 1'b0;
      ptr_q       <= '0;
      rptr_q      <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      rptr_q  <= rd_sel;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cvdt_pkg::REG_TABLE_ENTRIES:  entries_q <= cfg_data_i;
          cvdt_pkg::REG_STENCIL_ENABLE: sten_en_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (state_q == S_IDLE && req_valid_i) begin
        case (table_kind_i)
          cvdt_pkg::KIND_COLOR:   cnt_q <= (CW+1)'(used_q[0]);
          cvdt_pkg::KIND_DEPTH:   cnt_q <= (CW+1)'(used_q[1]);
          cvdt_pkg::KIND_STENCIL: cnt_q <= (CW+1)'(used_q[2]);
          default:                cnt_q <= '0;
        endcase
      end else if (state_q == S_CHECK && cnt_q != '0) begin
        cnt_q <= cnt_q - (CW+1)'(1);
      end
      if (wr_en) begin
        vld_q[ti][wr_addr] <= 1'b1;
        if (state_q == S_CHECK && !(cnt_q != '0 && hit)) used_q[ti] <= used_q[ti] + CW'(1);
      end
      if (state_d == S_OUT && state_q != S_OUT) rsp_valid_q <= 1'b1;
      else if (state_q == S_OUT && !rsp_stall_i) rsp_valid_q <= 1'b0;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_valid_i) begin
      kind_q <= table_kind_i;
      idx_q  <= entry_index_i;
      key_q.ds_low  <= color_ds_low_i;
      key_q.ds_high <= color_ds_high_i;
      key_q.l2_low  <= color_l2_low_i;
      key_q.l2_high <= color_l2_high_i;
      key_q.value   <= (table_kind_i == cvdt_pkg::KIND_COLOR) ? 32'd0 : depth_value_i;
      key_q.fmt     <= format_i;
      key_q.refs    <= 16'd1;
      rd_q   <= '0;
      new_q  <= 1'b0;
      slot_q <= '0;
      if (table_kind_i == cvdt_pkg::KIND_NONE && operation_i == cvdt_pkg::OP_QUERY) begin
        status_q <= cvdt_pkg::ST_OK;
        slot_q   <= 5'(eff);
      end else begin
        status_q <= cvdt_pkg::ST_INVALID;
      end
    end else if (state_q == S_QRD) begin
      if (32'(idx_q) >= 32'(eff)) begin
        status_q <= cvdt_pkg::ST_INVALID;
      end else begin
        status_q <= cvdt_pkg::ST_OK;
        slot_q   <= 5'(idx_q);
        rd_q     <= rd_eff;
      end
    end else if (state_q == S_CHECK) begin
      if (cnt_q != '0 && hit) begin
        status_q <= cvdt_pkg::ST_OK;
        slot_q   <= 5'(rptr_q);
      end else if (cnt_q <= (CW+1)'(1)) begin
        if (used_q[ti] < eff) begin
          status_q <= cvdt_pkg::ST_OK;
          slot_q   <= 5'(used_q[ti]);
          new_q    <= 1'b1;
        end else begin
          status_q <= (kind_q == cvdt_pkg::KIND_STENCIL) ? cvdt_pkg::ST_FULL_STENCIL
                      : cvdt_pkg::ST_FULL;
        end
      end
    end
  end

  assign rsp_valid_o    = rsp_valid_q;
  assign status_o       = status_q;
  assign slot_index_o   = slot_q;
  assign wrote_new_o    = new_q;
  assign read_format_o  = rd_q.fmt;
  assign ref_count_o    = rd_q.refs;
  assign read_ds_low_o  = rd_q.ds_low;
  assign read_ds_high_o = rd_q.ds_high;
  assign read_l2_low_o  = rd_q.l2_low;
  assign read_l2_high_o = rd_q.l2_high;
  assign read_depth_o   = rd_q.value;

  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_valid_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q == (state_q == S_OUT)) else $error("response valid out of step");
  a_new_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && new_q |-> status_q == cvdt_pkg::ST_OK) else $error("append not ok");
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q[0] <= CW'(TableDepth) && used_q[1] <= CW'(TableDepth)
    && used_q[2] <= CW'(TableDepth)) else $error("used count overflow");

endmodule
